### hw/rtl/bun_pkg.sv
// shared constants, types and helpers for the boundary unit normal block
// used by every module under hw/rtl; depends on nothing
package bun_pkg;

  localparam int VEC_W      = 64;
  localparam int IN_W       = 32;
  localparam int MAG_W      = 30;
  localparam int SQ_W       = 2 * MAG_W + 2;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CHUNK_W    = 8;
  localparam int NUM_CHUNK  = VEC_W / CHUNK_W;
  localparam int SH_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THR  = 2'd2;

  typedef struct packed {
    logic vld;
    logic deg;
  } norm_stat_t;

  // position of the highest set bit in a byte, zero when empty
  function automatic logic [2:0] lead8(input logic [CHUNK_W-1:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (b[i]) pos = 3'(i);
    end
    return pos;
  endfunction

endpackage

### hw/rtl/boundary_unit_normal.sv
// top level: cross products, two normalizers in series, result select
// depends on bun_pkg, bun_norm (and through it the root and divider cells)

// Takes one request per clock (busy is always low) and returns one result per
// request, in order. Each of the two normalizers in series is a 31-cell
// square-root chain followed by an OUT_FRAC_BITS+1 cell divider chain plus
// setup and product stages; out_valid pulses for one cycle and the result is
// not held. Registers may be written only while no request is in flight.
module boundary_unit_normal #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [bun_pkg::IN_W-1:0]    in_ax,
  input  logic signed [bun_pkg::IN_W-1:0]    in_ay,
  input  logic signed [bun_pkg::IN_W-1:0]    in_az,
  input  logic signed [bun_pkg::IN_W-1:0]    in_bx,
  input  logic signed [bun_pkg::IN_W-1:0]    in_by_comp,
  input  logic signed [bun_pkg::IN_W-1:0]    in_bz,
  input  logic signed [bun_pkg::IN_W-1:0]    in_cx,
  input  logic signed [bun_pkg::IN_W-1:0]    in_cy,
  input  logic signed [bun_pkg::IN_W-1:0]    in_cz,
  output logic                               out_valid,
  output logic signed [bun_pkg::IN_W-1:0]    out_nx,
  output logic signed [bun_pkg::IN_W-1:0]    out_ny,
  output logic signed [bun_pkg::IN_W-1:0]    out_nz,
  output logic                               out_degenerate,
  input  logic                               cfg_we,
  input  logic [bun_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bun_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bun_pkg::*;

  localparam int F        = OUT_FRAC_BITS;
  localparam int RW       = F + 2;
  localparam int PRW      = IN_W + RW;
  localparam int NORM_LAT = ROOT_W + F + 9;
  localparam int LAT      = 2 * NORM_LAT + 6;
  localparam int P2W      = 2 * 3 * RW + 1;
  localparam logic [RW-1:0] ONE_R    = RW'(1) << F;
  localparam logic [VEC_W:0] HALF_IN = (VEC_W+1)'(1) << (IN_FRAC_BITS - 1);
  localparam logic [VEC_W:0] ONE_W   = (VEC_W+1)'(1) << F;

  // configuration
  logic                  mode_r;
  logic                  negate_r;
  logic [CFG_DATA_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      negate_r <= 1'b0;
      thr_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE: mode_r   <= cfg_wdata[0];
        CFG_NEG:  negate_r <= cfg_wdata[0];
        CFG_THR:  thr_r    <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: capture request
  logic                     v0_r;
  logic signed [IN_W-1:0]   a0_r [3];
  logic signed [IN_W-1:0]   b0_r [3];
  logic [2:0][IN_W-1:0]     c0_r;
  // stage 1: a x b products
  logic                     v1_r;
  logic signed [VEC_W-1:0]  pab1_r [6];
  logic [2:0][IN_W-1:0]     c1_r;
  // stage 2: a x b
  logic                     v2_r;
  logic [2:0][VEC_W-1:0]    p2_r;
  logic [2:0][IN_W-1:0]     c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    a0_r[0] <= in_ax;
    a0_r[1] <= in_ay;
    a0_r[2] <= in_az;
    b0_r[0] <= in_bx;
    b0_r[1] <= in_by_comp;
    b0_r[2] <= in_bz;
    c0_r    <= {in_cz, in_cy, in_cx};

    pab1_r[0] <= a0_r[1] * b0_r[2];
    pab1_r[1] <= a0_r[2] * b0_r[1];
    pab1_r[2] <= a0_r[2] * b0_r[0];
    pab1_r[3] <= a0_r[0] * b0_r[2];
    pab1_r[4] <= a0_r[0] * b0_r[1];
    pab1_r[5] <= a0_r[1] * b0_r[0];
    c1_r      <= c0_r;

    p2_r[0] <= VEC_W'(pab1_r[0] - pab1_r[1]);
    p2_r[1] <= VEC_W'(pab1_r[2] - pab1_r[3]);
    p2_r[2] <= VEC_W'(pab1_r[4] - pab1_r[5]);
    c2_r    <= c1_r;
  end

  // first normalizer: unit a x b
  norm_stat_t            st1;
  logic [2:0][RW-1:0]    res1;
  logic [3*IN_W-1:0]     c_n1;

  bun_norm #(.K(IN_FRAC_BITS), .F(F), .PW(3 * IN_W)) u_norm_ab (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v2_r),
    .vec_i  (p2_r),
    .thr_i  (thr_r),
    .pass_i (c2_r),
    .stat_o (st1),
    .res_o  (res1),
    .pass_o (c_n1)
  );

  // stage 3: surface normal select, c x s products
  logic [2:0][RW-1:0]     s_sel;
  logic [2:0][RW-1:0]     r1_nxt;
  logic signed [IN_W-1:0] cv [3];
  logic signed [RW-1:0]   sv [3];
  logic                   v3_r;
  logic signed [PRW-1:0]  pcs3_r [6];
  logic [2:0][RW-1:0]     r1_3_r;
  logic                   deg3_r;

  always_comb begin
    s_sel[0] = st1.deg ? '0 : res1[0];
    s_sel[1] = st1.deg ? '0 : res1[1];
    s_sel[2] = st1.deg ? ONE_R : res1[2];
    for (int i = 0; i < 3; i++) begin
      r1_nxt[i] = negate_r ? RW'(0) - s_sel[i] : s_sel[i];
      cv[i]     = $signed(c_n1[i*IN_W +: IN_W]);
      sv[i]     = $signed(s_sel[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= st1.vld;
    end
  end

  always_ff @(posedge clk) begin
    pcs3_r[0] <= cv[1] * sv[2];
    pcs3_r[1] <= cv[2] * sv[1];
    pcs3_r[2] <= cv[2] * sv[0];
    pcs3_r[3] <= cv[0] * sv[2];
    pcs3_r[4] <= cv[0] * sv[1];
    pcs3_r[5] <= cv[1] * sv[0];
    r1_3_r    <= r1_nxt;
    deg3_r    <= st1.deg;
  end

  // stage 4: c x s with sign applied
  logic                    v4_r;
  logic [2:0][VEC_W-1:0]   n4_r;
  logic [2:0][RW-1:0]      r1_4_r;
  logic                    deg4_r;
  logic [2:0][VEC_W-1:0]   n_nxt;

  always_comb begin
    n_nxt[0] = VEC_W'(pcs3_r[0]) - VEC_W'(pcs3_r[1]);
    n_nxt[1] = VEC_W'(pcs3_r[2]) - VEC_W'(pcs3_r[3]);
    n_nxt[2] = VEC_W'(pcs3_r[4]) - VEC_W'(pcs3_r[5]);
    for (int i = 0; i < 3; i++) begin
      if (negate_r) n_nxt[i] = VEC_W'(0) - n_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    n4_r   <= n_nxt;
    r1_4_r <= r1_3_r;
    deg4_r <= deg3_r;
  end

  // unnormalized fallback: drop input fraction, round half away from zero
  logic [2:0][RW-1:0] sho;
  logic [VEC_W-1:0]   n_mag;
  logic [VEC_W:0]     n_q;

  always_comb begin
    n_mag = '0;
    n_q   = '0;
    for (int i = 0; i < 3; i++) begin
      n_mag  = n4_r[i][VEC_W-1] ? VEC_W'(0) - n4_r[i] : n4_r[i];
      n_q    = ((VEC_W+1)'(n_mag) + HALF_IN) >> IN_FRAC_BITS;
      if (n_q > ONE_W) n_q = ONE_W;
      sho[i] = n4_r[i][VEC_W-1] ? RW'(0) - RW'(n_q) : RW'(n_q);
    end
  end

  // second normalizer: unit c x s
  norm_stat_t          st2;
  logic [2:0][RW-1:0]  res2;
  logic [P2W-1:0]      pass2;
  logic [2:0][RW-1:0]  r1_o;
  logic [2:0][RW-1:0]  sho_o;
  logic                deg1_o;

  bun_norm #(.K(IN_FRAC_BITS + F), .F(F), .PW(P2W)) u_norm_cs (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v4_r),
    .vec_i  (n4_r),
    .thr_i  (thr_r),
    .pass_i ({r1_4_r, deg4_r, sho}),
    .stat_o (st2),
    .res_o  (res2),
    .pass_o (pass2)
  );

  assign sho_o  = pass2[3*RW-1:0];
  assign deg1_o = pass2[3*RW];
  assign r1_o   = pass2[P2W-1 -: 3*RW];

  // output register
  logic                out_valid_r;
  logic [2:0][RW-1:0]  res_sel;
  logic [2:0][RW-1:0]  out_r;
  logic                deg_r;

  always_comb begin
    if (mode_r) begin
      res_sel = r1_o;
    end else if (st2.deg) begin
      res_sel = sho_o;
    end else begin
      res_sel = res2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st2.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= res_sel;
    deg_r <= mode_r ? deg1_o : (deg1_o | st2.deg);
  end

  assign out_valid      = out_valid_r;
  assign out_nx         = IN_W'($signed(out_r[0]));
  assign out_ny         = IN_W'($signed(out_r[1]));
  assign out_nz         = IN_W'($signed(out_r[2]));
  assign out_degenerate = deg_r;

`ifndef SYNTH
  localparam logic signed [IN_W-1:0] ONE_O = IN_W'(1) << F;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result strobe missing at fixed latency");

  a_face_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode_r && out_degenerate) |-> (out_nx == '0 && out_ny == '0))
    else $error("face fallback normal not along z");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nx <= ONE_O && out_nx >= -ONE_O && out_ny <= ONE_O &&
                   out_ny >= -ONE_O && out_nz <= ONE_O && out_nz >= -ONE_O))
    else $error("normal component beyond unit magnitude");
`endif

endmodule

### hw/rtl/bun_sqrt_cell.sv
// one digit of the integer square root chain
// depends on bun_pkg
module bun_sqrt_cell #(
  parameter int PW = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         vld_i,
  input  logic [bun_pkg::REM_W-1:0]    rem_i,
  input  logic [bun_pkg::ROOT_W-1:0]   root_i,
  input  logic [bun_pkg::SQ_W-1:0]     rad_i,
  input  logic [PW-1:0]                pass_i,
  output logic                         vld_o,
  output logic [bun_pkg::REM_W-1:0]    rem_o,
  output logic [bun_pkg::ROOT_W-1:0]   root_o,
  output logic [bun_pkg::SQ_W-1:0]     rad_o,
  output logic [PW-1:0]                pass_o
);
  import bun_pkg::*;

  logic               vld_r;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  root_r;
  logic [SQ_W-1:0]    rad_r;
  logic [PW-1:0]      pass_r;
  logic [REM_W+1:0]   rem_sh, trial;
  logic               ge;

  always_comb begin
    rem_sh  = {rem_i, rad_i[SQ_W-1 -: 2]};
    trial   = (REM_W+2)'({root_i, 2'b01});
    ge      = rem_sh >= trial;
    rem_nxt = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= {root_i[ROOT_W-2:0], ge};
    rad_r  <= {rad_i[SQ_W-3:0], 2'b00};
    pass_r <= pass_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign pass_o = pass_r;

endmodule

### hw/rtl/bun_div_cell.sv
// one quotient bit of the three-lane restoring divider chain
// depends on bun_pkg
module bun_div_cell #(
  parameter int QW = 31,
  parameter int PW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [bun_pkg::ROOT_W-1:0]        dsr_i,
  input  logic [2:0][bun_pkg::ROOT_W-1:0]   rem_i,
  input  logic [2:0][QW-1:0]                quo_i,
  input  logic [2:0][QW-1:0]                dvd_i,
  input  logic [PW-1:0]                     pass_i,
  output logic                              vld_o,
  output logic [bun_pkg::ROOT_W-1:0]        dsr_o,
  output logic [2:0][bun_pkg::ROOT_W-1:0]   rem_o,
  output logic [2:0][QW-1:0]                quo_o,
  output logic [2:0][QW-1:0]                dvd_o,
  output logic [PW-1:0]                     pass_o
);
  import bun_pkg::*;

  logic                    vld_r;
  logic [ROOT_W-1:0]       dsr_r;
  logic [2:0][ROOT_W-1:0]  rem_r, rem_nxt;
  logic [2:0][QW-1:0]      quo_r, quo_nxt;
  logic [2:0][QW-1:0]      dvd_r;
  logic [PW-1:0]           pass_r;
  logic [ROOT_W:0]         t;
  logic                    ge;

  always_comb begin
    t  = '0;
    ge = 1'b0;
    for (int l = 0; l < 3; l++) begin
      t          = {rem_i[l], dvd_i[l][QW-1]};
      ge         = t >= {1'b0, dsr_i};
      rem_nxt[l] = ge ? ROOT_W'(t - {1'b0, dsr_i}) : ROOT_W'(t);
      quo_nxt[l] = {quo_i[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    dsr_r  <= dsr_i;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    for (int l = 0; l < 3; l++) begin
      dvd_r[l] <= {dvd_i[l][QW-2:0], 1'b0};
    end
    pass_r <= pass_i;
  end

  assign vld_o  = vld_r;
  assign dsr_o  = dsr_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign dvd_o  = dvd_r;
  assign pass_o = pass_r;

endmodule

### hw/rtl/bun_norm.sv
// vector normalizer: degenerate test, shift to 30 bits, root chain, divider chain
// depends on bun_pkg, bun_sqrt_cell, bun_div_cell
module bun_norm #(
  parameter int K  = 16,
  parameter int F  = 30,
  parameter int PW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              vld_i,
  input  logic [2:0][bun_pkg::VEC_W-1:0]    vec_i,
  input  logic [bun_pkg::CFG_DATA_W-1:0]    thr_i,
  input  logic [PW-1:0]                     pass_i,
  output bun_pkg::norm_stat_t               stat_o,
  output logic [2:0][F+1:0]                 res_o,
  output logic [PW-1:0]                     pass_o
);
  import bun_pkg::*;

  localparam int QW  = F + 1;
  localparam int DW  = MAG_W + F + 1;
  localparam int TW  = (2 * K + 32 > 128) ? 2 * K + 32 : 128;
  localparam int SPW = PW + 1 + 3 + 3 * MAG_W;
  localparam int DPW = PW + 1 + 3;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << F;

  logic [TW-1:0] thr_sq_r;
  logic [31:0]   thr_prod;

  // stage 1: magnitudes
  logic                   v1_r;
  logic [2:0][VEC_W-1:0]  mag1_r;
  logic [2:0]             neg1_r;
  logic [PW-1:0]          pass1_r;
  // stage 2: partial squares, byte leading-one info
  logic                   v2_r;
  logic [2:0][63:0]       hh2_r, hl2_r, ll2_r;
  logic [NUM_CHUNK-1:0]   nz2_r;
  logic [NUM_CHUNK-1:0][2:0] top2_r;
  logic [2:0][VEC_W-1:0]  mag2_r;
  logic [2:0]             neg2_r;
  logic [PW-1:0]          pass2_r;
  logic [VEC_W-1:0]       or_v;
  // stage 3
  logic                   v3_r;
  logic [2:0][127:0]      sq3_r;
  logic [SH_W-1:0]        sh3_r;
  logic [2:0][VEC_W-1:0]  mag3_r;
  logic [2:0]             neg3_r;
  logic [PW-1:0]          pass3_r;
  logic [6:0]             bl;
  // stage 4
  logic                   v4_r;
  logic [127:0]           sum4_r;
  logic [2:0][MAG_W-1:0]  m4_r;
  logic [2:0]             neg4_r;
  logic [PW-1:0]          pass4_r;
  // stage 5
  logic                   v5_r;
  logic                   small5_r;
  logic [2:0][2*MAG_W-1:0] msq5_r;
  logic [2:0][MAG_W-1:0]  m5_r;
  logic [2:0]             neg5_r;
  logic [PW-1:0]          pass5_r;
  // stage 6
  logic                   v6_r;
  logic                   small6_r;
  logic [SQ_W-1:0]        s2_r;
  logic [2:0][MAG_W-1:0]  m6_r;
  logic [2:0]             neg6_r;
  logic [PW-1:0]          pass6_r;

  always_comb begin
    thr_prod = 32'(thr_i) * 32'(thr_i);
    or_v     = mag1_r[0] | mag1_r[1] | mag1_r[2];
    bl       = '0;
    for (int c = 0; c < NUM_CHUNK; c++) begin
      if (nz2_r[c]) bl = 7'(c * CHUNK_W) + 7'(top2_r[c]) + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    thr_sq_r <= TW'(thr_prod) << (2 * K);
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= vec_i[i][VEC_W-1];
      mag1_r[i] <= vec_i[i][VEC_W-1] ? VEC_W'(0) - vec_i[i] : vec_i[i];

      hh2_r[i]  <= mag1_r[i][63:32] * mag1_r[i][63:32];
      hl2_r[i]  <= mag1_r[i][63:32] * mag1_r[i][31:0];
      ll2_r[i]  <= mag1_r[i][31:0] * mag1_r[i][31:0];

      sq3_r[i]  <= {hh2_r[i], 64'd0} + (128'(hl2_r[i]) << 33) + 128'(ll2_r[i]);

      m4_r[i]   <= MAG_W'(mag3_r[i] >> sh3_r);
      msq5_r[i] <= m4_r[i] * m4_r[i];
    end
    for (int c = 0; c < NUM_CHUNK; c++) begin
      nz2_r[c]  <= |or_v[c*CHUNK_W +: CHUNK_W];
      top2_r[c] <= lead8(or_v[c*CHUNK_W +: CHUNK_W]);
    end
    pass1_r  <= pass_i;
    mag2_r   <= mag1_r;
    neg2_r   <= neg1_r;
    pass2_r  <= pass1_r;
    sh3_r    <= (bl > 7'(MAG_W)) ? SH_W'(bl - 7'(MAG_W)) : '0;
    mag3_r   <= mag2_r;
    neg3_r   <= neg2_r;
    pass3_r  <= pass2_r;
    sum4_r   <= sq3_r[0] + sq3_r[1] + sq3_r[2];
    neg4_r   <= neg3_r;
    pass4_r  <= pass3_r;
    small5_r <= TW'(sum4_r) <= thr_sq_r;
    m5_r     <= m4_r;
    neg5_r   <= neg4_r;
    pass5_r  <= pass4_r;
    small6_r <= small5_r;
    s2_r     <= SQ_W'(msq5_r[0]) + SQ_W'(msq5_r[1]) + SQ_W'(msq5_r[2]);
    m6_r     <= m5_r;
    neg6_r   <= neg5_r;
    pass6_r  <= pass5_r;
  end

  // root chain, two radicand bits per cell
  logic               sq_vld  [ROOT_W+1];
  logic [REM_W-1:0]   sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]  sq_root [ROOT_W+1];
  logic [SQ_W-1:0]    sq_rad  [ROOT_W+1];
  logic [SPW-1:0]     sq_pass [ROOT_W+1];

  assign sq_vld[0]  = v6_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = s2_r;
  assign sq_pass[0] = {small6_r, neg6_r, m6_r, pass6_r};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    bun_sqrt_cell #(.PW(SPW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (sq_vld[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .rad_i  (sq_rad[g]),
      .pass_i (sq_pass[g]),
      .vld_o  (sq_vld[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .rad_o  (sq_rad[g+1]),
      .pass_o (sq_pass[g+1])
    );
  end

  // stage 7: rounding dividend setup
  logic [SPW-1:0]          sq_out;
  logic [2:0][MAG_W-1:0]   m_sq;
  logic [ROOT_W-1:0]       n_safe;
  logic [2:0][DW-1:0]      dvd_full;
  logic                    v7_r;
  logic [ROOT_W-1:0]       dsr7_r;
  logic [2:0][ROOT_W-1:0]  rem7_r;
  logic [2:0][QW-1:0]      dvd7_r;
  logic [DPW-1:0]          pass7_r;

  always_comb begin
    sq_out = sq_pass[ROOT_W];
    m_sq   = sq_out[PW +: 3*MAG_W];
    n_safe = (sq_root[ROOT_W] == '0) ? ROOT_W'(1) : sq_root[ROOT_W];
    for (int i = 0; i < 3; i++) begin
      dvd_full[i] = (DW'(m_sq[i]) << F) + DW'(n_safe >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= sq_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    dsr7_r <= n_safe;
    for (int i = 0; i < 3; i++) begin
      rem7_r[i] <= ROOT_W'(dvd_full[i] >> QW);
      dvd7_r[i] <= dvd_full[i][QW-1:0];
    end
    pass7_r <= {sq_out[SPW-1], sq_out[PW + 3*MAG_W +: 3], sq_out[PW-1:0]};
  end

  // divider chain, one quotient bit per cell
  logic                    dv_vld  [QW+1];
  logic [ROOT_W-1:0]       dv_dsr  [QW+1];
  logic [2:0][ROOT_W-1:0]  dv_rem  [QW+1];
  logic [2:0][QW-1:0]      dv_quo  [QW+1];
  logic [2:0][QW-1:0]      dv_dvd  [QW+1];
  logic [DPW-1:0]          dv_pass [QW+1];

  assign dv_vld[0]  = v7_r;
  assign dv_dsr[0]  = dsr7_r;
  assign dv_rem[0]  = rem7_r;
  assign dv_quo[0]  = '0;
  assign dv_dvd[0]  = dvd7_r;
  assign dv_pass[0] = pass7_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    bun_div_cell #(.QW(QW), .PW(DPW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (dv_vld[g]),
      .dsr_i  (dv_dsr[g]),
      .rem_i  (dv_rem[g]),
      .quo_i  (dv_quo[g]),
      .dvd_i  (dv_dvd[g]),
      .pass_i (dv_pass[g]),
      .vld_o  (dv_vld[g+1]),
      .dsr_o  (dv_dsr[g+1]),
      .rem_o  (dv_rem[g+1]),
      .quo_o  (dv_quo[g+1]),
      .dvd_o  (dv_dvd[g+1]),
      .pass_o (dv_pass[g+1])
    );
  end

  // stage 8: clamp and sign
  logic [DPW-1:0]      dv_out;
  logic [2:0][QW-1:0]  q_cl;
  logic                v8_r;
  logic                small8_r;
  logic [2:0][F+1:0]   res8_r;
  logic [PW-1:0]       pass8_r;

  always_comb begin
    dv_out = dv_pass[QW];
    for (int i = 0; i < 3; i++) begin
      q_cl[i] = (dv_quo[QW][i] > ONE_Q) ? ONE_Q : dv_quo[QW][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    small8_r <= dv_out[DPW-1];
    for (int i = 0; i < 3; i++) begin
      res8_r[i] <= dv_out[PW + i] ? (F+2)'(0) - (F+2)'(q_cl[i]) : (F+2)'(q_cl[i]);
    end
    pass8_r <= dv_out[PW-1:0];
  end

  assign stat_o.vld = v8_r;
  assign stat_o.deg = small8_r;
  assign res_o      = res8_r;
  assign pass_o     = pass8_r;

endmodule

### tb/boundary_unit_normal_tb.sv
// self-checking testbench for boundary_unit_normal: directed and random requests
// under several register settings, checked against an in-bench fixed-point predictor
// depends on bun_pkg and the boundary_unit_normal rtl
`timescale 1ns / 1ps

module boundary_unit_normal_tb;
  import bun_pkg::*;

  localparam int  OUT_FB      = 30;
  localparam int  IN_FB       = 16;
  localparam int  PHASES      = 6;
  localparam int  RAND_PER_PH = 64;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  DRAIN       = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [IN_W-1:0] a [3];
    logic signed [IN_W-1:0] b [3];
    logic signed [IN_W-1:0] c [3];
  } tangents_t;

  typedef struct {
    logic [IN_W-1:0] nx;
    logic [IN_W-1:0] ny;
    logic [IN_W-1:0] nz;
    logic            degenerate;
  } normal_t;

  class normal_scoreboard;
    bit          mode_r;
    bit          neg_r;
    logic [15:0] thr_r;
    normal_t     pending [$];
    int          errors;
    int          checked;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_MODE) mode_r = val[0];
      else if (idx == CFG_NEG) neg_r = val[0];
      else if (idx == CFG_THR) thr_r = val;
    endfunction

    function logic [63:0] mag(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function vec3_t cross3(vec3_t p, vec3_t q);
      vec3_t r;
      r[0] = p[1] * q[2] - p[2] * q[1];
      r[1] = p[2] * q[0] - p[0] * q[2];
      r[2] = p[0] * q[1] - p[1] * q[0];
      return r;
    endfunction

    // norm at or below threshold << k, compared exactly in squares
    function bit below_thr(vec3_t v, int k);
      logic [127:0] sum, t;
      sum = 0;
      for (int i = 0; i < 3; i++) sum += 128'(mag(v[i])) * 128'(mag(v[i]));
      t = 128'({48'd0, thr_r} << k);
      return sum <= t * t;
    endfunction

    function logic [63:0] root(logic [63:0] x);
      logic [63:0] r, b4;
      r = 0;
      b4 = 64'd1 << 62;
      while (b4 > x) b4 >>= 2;
      while (b4 != 0) begin
        if (x >= r + b4) begin
          x -= r + b4;
          r = (r >> 1) + b4;
        end else begin
          r >>= 1;
        end
        b4 >>= 2;
      end
      return r;
    endfunction

    function vec3_t unit(vec3_t v);
      logic [63:0] m [3];
      logic [63:0] mx, s2, n, q;
      int sh;
      vec3_t r;
      for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 30)) sh++;
      for (int i = 0; i < 3; i++) m[i] >>= sh;
      s2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      n = root(s2);
      if (n == 0) n = 1;
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << OUT_FB) + (n >> 1)) / n;
        if (q > (64'd1 << OUT_FB)) q = 64'd1 << OUT_FB;
        r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return r;
    endfunction

    function longint round_out(longint x);
      logic [63:0] q;
      q = (mag(x) + (64'd1 << (IN_FB - 1))) >> IN_FB;
      if (q > (64'd1 << OUT_FB)) q = 64'd1 << OUT_FB;
      return x < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note_request(tangents_t t);
      vec3_t a, b, c, p, s, n, r;
      normal_t e;
      bit deg;
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'(t.a[i]);
        b[i] = longint'(t.b[i]);
        c[i] = longint'(t.c[i]);
      end
      deg = 0;
      p = cross3(a, b);
      if (!mode_r) begin
        if (below_thr(p, IN_FB)) begin
          s[0] = 0; s[1] = 0; s[2] = longint'(1) << OUT_FB;
          deg = 1;
        end else begin
          s = unit(p);
        end
        n = cross3(c, s);
        if (neg_r) for (int i = 0; i < 3; i++) n[i] = -n[i];
        if (below_thr(n, IN_FB + OUT_FB)) begin
          for (int i = 0; i < 3; i++) r[i] = round_out(n[i]);
          deg = 1;
        end else begin
          r = unit(n);
        end
      end else begin
        if (below_thr(p, IN_FB)) begin
          r[0] = 0; r[1] = 0; r[2] = longint'(1) << OUT_FB;
          deg = 1;
        end else begin
          r = unit(p);
        end
        if (neg_r) for (int i = 0; i < 3; i++) r[i] = -r[i];
      end
      e.nx = r[0][31:0];
      e.ny = r[1][31:0];
      e.nz = r[2][31:0];
      e.degenerate = deg;
      pending.push_back(e);
    endfunction

    function void check_result(normal_t got);
      normal_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: result with no request pending: %h %h %h %b", $time,
                 got.nx, got.ny, got.nz, got.degenerate);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.nx !== e.nx) begin
        $display("%0t: nx expected %h actual %h", $time, e.nx, got.nx);
        errors++;
      end
      if (got.ny !== e.ny) begin
        $display("%0t: ny expected %h actual %h", $time, e.ny, got.ny);
        errors++;
      end
      if (got.nz !== e.nz) begin
        $display("%0t: nz expected %h actual %h", $time, e.nz, got.nz);
        errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $display("%0t: degenerate expected %b actual %b", $time, e.degenerate,
                 got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [IN_W-1:0]  in_ax, in_ay, in_az, in_bx, in_by_comp, in_bz;
  logic signed [IN_W-1:0]  in_cx, in_cy, in_cz;
  logic                    out_valid;
  logic signed [IN_W-1:0]  out_nx, out_ny, out_nz;
  logic                    out_degenerate;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_idx;
  logic [CFG_DATA_W-1:0]   cfg_wdata;

  normal_scoreboard sb;
  int cycles;
  int sent;
  int gap_pct;

  boundary_unit_normal i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by_comp(in_by_comp), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .out_valid(out_valid), .out_nx(out_nx), .out_ny(out_ny), .out_nz(out_nz),
    .out_degenerate(out_degenerate),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("boundary_unit_normal regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    normal_t got;
    if (rst_n && out_valid) begin
      got.nx = out_nx;
      got.ny = out_ny;
      got.nz = out_nz;
      got.degenerate = out_degenerate;
      sb.check_result(got);
    end
  end

  function automatic tangents_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                                   int c0, int c1, int c2);
    tangents_t t;
    t.a[0] = a0; t.a[1] = a1; t.a[2] = a2;
    t.b[0] = b0; t.b[1] = b1; t.b[2] = b2;
    t.c[0] = c0; t.c[1] = c1; t.c[2] = c2;
    return t;
  endfunction

  function automatic int srand(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // mostly shaped requests that reach the threshold and unnormalized paths
  function automatic tangents_t random_request();
    tangents_t t;
    int k;
    for (int i = 0; i < 3; i++) begin
      t.a[i] = $urandom;
      t.b[i] = $urandom;
      t.c[i] = $urandom;
    end
    case ($urandom_range(0, 4))
      1: for (int i = 0; i < 3; i++) begin
        t.a[i] = srand(300);
        t.b[i] = srand(300);
        t.c[i] = srand(70000);
      end
      2: begin
        k = srand(3);
        for (int i = 0; i < 3; i++) begin
          t.a[i] = srand(1000);
          t.b[i] = t.a[i] * k + srand(1);
        end
      end
      3: begin
        // surface normal along z, edge tangent nearly along it too
        t.a[0] = srand(1 << 20); t.a[1] = srand(4); t.a[2] = srand(4);
        t.b[0] = srand(4); t.b[1] = srand(1 << 20); t.b[2] = srand(4);
        t.c[0] = srand(2); t.c[1] = srand(2); t.c[2] = $urandom;
      end
      4: for (int i = 0; i < 3; i++) t.c[i] = srand(3);
      default: ;
    endcase
    return t;
  endfunction

  task automatic write_regs(bit m, bit ng, logic [15:0] thr);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MODE;
    cfg_wdata <= {15'($urandom), m};
    sb.set_reg(CFG_MODE, {15'd0, m});
    @(posedge clk);
    cfg_idx <= CFG_NEG;
    cfg_wdata <= {15'($urandom), ng};
    sb.set_reg(CFG_NEG, {15'd0, ng});
    @(posedge clk);
    cfg_idx <= CFG_THR;
    cfg_wdata <= thr;
    sb.set_reg(CFG_THR, thr);
    @(posedge clk);
    // unused index must leave every register alone
    cfg_idx <= CFG_SPARE;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send(tangents_t t);
    start <= 1'b1;
    in_ax <= t.a[0]; in_ay <= t.a[1]; in_az <= t.a[2];
    in_bx <= t.b[0]; in_by_comp <= t.b[1]; in_bz <= t.b[2];
    in_cx <= t.c[0]; in_cy <= t.c[1]; in_cz <= t.c[2];
    do @(posedge clk); while (busy);
    sb.note_request(t);
    sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  localparam int MX = 32'h7fffffff;
  localparam int MN = 32'h80000000;
  localparam int ONE = 1 << 16;

  initial begin
    tangents_t directed [$];
    bit          ph_mode [PHASES];
    bit          ph_neg  [PHASES];
    logic [15:0] ph_thr  [PHASES];
    ph_mode = '{0, 1, 0, 1, 0, 1};
    ph_neg  = '{0, 1, 1, 0, 0, 1};
    sb = new();
    sent = 0;
    gap_pct = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_ax <= 0; in_ay <= 0; in_az <= 0;
    in_bx <= 0; in_by_comp <= 0; in_bz <= 0;
    in_cx <= 0; in_cy <= 0; in_cz <= 0;
    ph_thr[0] = 16'd0;
    ph_thr[1] = 16'hffff;
    ph_thr[2] = 16'hffff;
    ph_thr[3] = 16'd0;
    ph_thr[4] = 16'($urandom_range(1, 300));
    ph_thr[5] = 16'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk(MX, MX, MX, MX, MX, MX, MX, MX, MX));
    directed.push_back(mk(MN, MN, MN, MN, MN, MN, MN, MN, MN));
    directed.push_back(mk(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0));
    directed.push_back(mk(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    directed.push_back(mk(ONE, 2, -3, 2 * ONE, 4, -6, 0, ONE, 0));
    directed.push_back(mk(MX, MN, MX, MN, MX, MN, MN, MX, MX));
    directed.push_back(mk(0, MN, MN, 0, MN, MX, MX, MN, 0));
    directed.push_back(mk(1, 0, 0, 0, 1, 0, 0, 1, 0));
    directed.push_back(mk(MN, 0, 0, 0, MN, 0, 0, MX, 0));
    directed.push_back(mk(ONE, ONE, 0, -ONE, ONE, 0, 0, 0, 0));
    directed.push_back(mk(32'h55555555, 32'haaaaaaaa, 32'h55555555,
                          32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                          32'h55555555, 32'haaaaaaaa, 32'h0000ffff));
    directed.push_back(mk(300, 0, 0, 0, 300, 0, 0, 0, MX));

    for (int ph = 0; ph < PHASES; ph++) begin
      gap_pct = ph < 2 ? 21 : (ph < 4 ? 61 : 0);
      write_regs(ph_mode[ph], ph_neg[ph], ph_thr[ph]);
      foreach (directed[i]) send(directed[i]);
      for (int i = 0; i < RAND_PER_PH; i++) send(random_request());
      drain();
    end

    repeat (DRAIN) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("covered %0d requests over %0d register settings (both modes, both signs,",
             sent, PHASES);
    $display("threshold zero and full scale), %0d results checked, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("boundary_unit_normal regression: pass");
    end else begin
      $display("boundary_unit_normal regression: fail");
    end
    $finish;
  end

endmodule
